// ===== hw/rtl/lrc_pkg.sv =====
// ============================================================================
// LRU/TTL result cache package
// Shared types, reset values and codes for the result cache and its cells.
// ============================================================================
package lrc_pkg;

  localparam int DEF_SLOTS       = 16;
  localparam int DEF_HANDLE_BITS = 16;

  localparam int TAG_W   = 64;
  localparam int STAMP_W = 64;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int REC_W   = 64;
  localparam int HOUT_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [TIME_W-1:0]  TTL_RESET         = 32'd5000;
  localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = 16'd10000;

  localparam logic [CFG_IDX_W-1:0] CFG_TTL_MS      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic valid;
    logic match;
    logic free_found;
    logic lru_set;
  } scan_flags_t;

  // Contents of the first matching slot, picked up on the way.
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [TIME_W-1:0]  stored_time;
    logic [COUNT_W-1:0] count;
  } match_data_t;

  // Update broadcast to all cells at the end of an item.
  typedef struct packed {
    logic store;
    logic clear;
    logic touch;
  } wr_cmd_t;

endpackage

// ===== hw/rtl/lrc_cell.sv =====
// ============================================================================
// LRU/TTL result cache slot cell
// Holds one slot and folds it into the search token passed along the row.
// ============================================================================
module lrc_cell import lrc_pkg::*; #(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS,
  parameter int CELL_IDX    = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // broadcast query
  input  logic [TAG_W-1:0]         q_tag,
  input  logic [STAMP_W-1:0]       q_stamp,
  input  logic [TIME_W-1:0]        q_time,
  input  logic [HANDLE_BITS-1:0]   q_handle,
  input  logic [COUNT_W-1:0]       q_count,
  // broadcast update
  input  wr_cmd_t                  wr,
  input  logic [$clog2(SLOTS)-1:0] wr_idx,
  input  logic [REC_W-1:0]         wr_rec,
  // token from left neighbor
  input  scan_flags_t              sin_flags,
  input  logic [$clog2(SLOTS)-1:0] sin_match_idx,
  input  logic [$clog2(SLOTS)-1:0] sin_free_idx,
  input  logic [$clog2(SLOTS)-1:0] sin_lru_idx,
  input  logic [REC_W-1:0]         sin_lru_rec,
  input  match_data_t              sin_data,
  input  logic [HANDLE_BITS-1:0]   sin_handle,
  // token to right neighbor
  output scan_flags_t              sout_flags,
  output logic [$clog2(SLOTS)-1:0] sout_match_idx,
  output logic [$clog2(SLOTS)-1:0] sout_free_idx,
  output logic [$clog2(SLOTS)-1:0] sout_lru_idx,
  output logic [REC_W-1:0]         sout_lru_rec,
  output match_data_t              sout_data,
  output logic [HANDLE_BITS-1:0]   sout_handle
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] ME = IDX_W'(CELL_IDX);

  logic                   valid_r;
  logic [TAG_W-1:0]       tag_r;
  logic [STAMP_W-1:0]     stamp_r;
  logic [TIME_W-1:0]      time_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [COUNT_W-1:0]     count_r;
  logic [REC_W-1:0]       rec_r;

  scan_flags_t            flags_r,     flags_nxt;
  logic [IDX_W-1:0]       match_idx_r, match_idx_nxt;
  logic [IDX_W-1:0]       free_idx_r,  free_idx_nxt;
  logic [IDX_W-1:0]       lru_idx_r,   lru_idx_nxt;
  logic [REC_W-1:0]       lru_rec_r,   lru_rec_nxt;
  match_data_t            data_r,      data_nxt;
  logic [HANDLE_BITS-1:0] handle_o_r,  handle_o_nxt;

  logic hit_here;
  logic take_match;
  logic take_lru;
  logic sel;

  assign hit_here   = valid_r && (tag_r == q_tag);
  assign take_match = hit_here && !sin_flags.match;
  assign take_lru   = !sin_flags.lru_set || (rec_r < sin_lru_rec);
  assign sel        = (wr_idx == ME);

  always_comb begin
    flags_nxt            = sin_flags;
    flags_nxt.match      = sin_flags.match | hit_here;
    flags_nxt.free_found = sin_flags.free_found | !valid_r;
    flags_nxt.lru_set    = 1'b1;
    match_idx_nxt        = take_match ? ME : sin_match_idx;
    data_nxt             = sin_data;
    handle_o_nxt         = sin_handle;
    if (take_match) begin
      data_nxt.stamp       = stamp_r;
      data_nxt.stored_time = time_r;
      data_nxt.count       = count_r;
      handle_o_nxt         = handle_r;
    end
    // later free slots override: highest free index wins
    free_idx_nxt = !valid_r ? ME : sin_free_idx;
    lru_idx_nxt  = take_lru ? ME : sin_lru_idx;
    lru_rec_nxt  = take_lru ? rec_r : sin_lru_rec;
  end

  // token stage: hand to neighbor every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    lru_idx_r   <= lru_idx_nxt;
    lru_rec_r   <= lru_rec_nxt;
    data_r      <= data_nxt;
    handle_o_r  <= handle_o_nxt;
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && wr.store) begin
      valid_r <= 1'b1;
    end else if (sel && wr.clear) begin
      valid_r <= 1'b0;
    end
    if (sel && wr.store) begin
      tag_r    <= q_tag;
      stamp_r  <= q_stamp;
      time_r   <= q_time;
      handle_r <= q_handle;
      count_r  <= q_count;
    end
    if (sel && (wr.store || wr.touch)) begin
      rec_r <= wr_rec;
    end
  end

  assign sout_flags     = flags_r;
  assign sout_match_idx = match_idx_r;
  assign sout_free_idx  = free_idx_r;
  assign sout_lru_idx   = lru_idx_r;
  assign sout_lru_rec   = lru_rec_r;
  assign sout_data      = data_r;
  assign sout_handle    = handle_o_r;

endmodule

// ===== hw/rtl/lru_ttl_result_cache_top.sv =====
// ============================================================================
// LRU/TTL result cache, top level
// Fully associative cache of listing results with LRU replacement and TTL.
// ============================================================================
// Usage:
//   Requests arrive on the in_ channel (valid/ready). A get (operation 0)
//   looks up key_tag; a put (operation 1) stores handle and count for it
//   unless the count exceeds max_entries. Every request produces exactly one
//   transfer on the out_ channel carrying hit / expired / stored flags, the
//   slot used and, on a hit, the stored handle and entry count.
//   The slots sit in a row of SLOTS cells. A search token enters cell 0 in
//   the cycle after the request transfer and moves one cell per cycle,
//   gathering first match, highest free slot and least recently used slot.
//   The token is captured as it leaves the last cell, then the finish step
//   writes the result; no new request is taken until the finish step is
//   done. Only one request is in flight at a time.
//   The result sits in an output register; while it waits, the next request
//   is accepted and searched. If the receiver still stalls when that search
//   ends, hold in the finish step until the output register frees.
//   cfg_we/cfg_index/cfg_wdata write ttl_ms (index 0) and max_entries
//   (index 1); write them only while no request is in flight.
//   Synchronous reset: all slots invalid, recency counter zero, registers
//   back to ttl 5000 ms and cap 10000 entries, both channels empty.
// ============================================================================
module lru_ttl_result_cache_top import lrc_pkg::*; #(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [TAG_W-1:0]     in_key_tag,
  input  logic [STAMP_W-1:0]   in_version_stamp,
  input  logic [TIME_W-1:0]    in_now_ms,
  input  logic [HOUT_W-1:0]    in_payload_handle,
  input  logic [COUNT_W-1:0]   in_entry_count,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic                 out_expired,
  output logic                 out_stored,
  output logic [SLOT_W-1:0]    out_slot_used,
  output logic [HOUT_W-1:0]    out_result_handle,
  output logic [COUNT_W-1:0]   out_result_count
);

  localparam int IDX_W = $clog2(SLOTS);

  // control
  state_t state_r, state_nxt;
  logic   start_r;
  logic   capture;
  logic   fire;
  logic   out_free;

  // configuration registers
  logic [TIME_W-1:0]  ttl_r;
  logic [COUNT_W-1:0] max_r;

  // request held for the whole search
  logic                   q_op_r;
  logic [TAG_W-1:0]       q_tag_r;
  logic [STAMP_W-1:0]     q_stamp_r;
  logic [TIME_W-1:0]      q_now_r;
  logic [HANDLE_BITS-1:0] q_handle_r;
  logic [COUNT_W-1:0]     q_count_r;

  logic [REC_W-1:0] rec_ctr_r;
  logic [REC_W-1:0] rec_inc;

  // token boundaries along the row
  scan_flags_t            ch_flags     [SLOTS+1];
  logic [IDX_W-1:0]       ch_match_idx [SLOTS+1];
  logic [IDX_W-1:0]       ch_free_idx  [SLOTS+1];
  logic [IDX_W-1:0]       ch_lru_idx   [SLOTS+1];
  logic [REC_W-1:0]       ch_lru_rec   [SLOTS+1];
  match_data_t            ch_data      [SLOTS+1];
  logic [HANDLE_BITS-1:0] ch_handle    [SLOTS+1];

  // search result captured from the end of the row
  scan_flags_t            res_flags_r;
  logic [IDX_W-1:0]       res_match_idx_r;
  logic [IDX_W-1:0]       res_free_idx_r;
  logic [IDX_W-1:0]       res_lru_idx_r;
  match_data_t            res_data_r;
  logic [HANDLE_BITS-1:0] res_handle_r;

  // cell update
  wr_cmd_t          wr;
  logic [IDX_W-1:0] wr_idx;

  // output register
  logic               out_valid_r;
  logic               out_hit_r,     out_hit_nxt;
  logic               out_expired_r, out_expired_nxt;
  logic               out_stored_r,  out_stored_nxt;
  logic [SLOT_W-1:0]  out_slot_r,    out_slot_nxt;
  logic [HOUT_W-1:0]  out_handle_r,  out_handle_nxt;
  logic [COUNT_W-1:0] out_count_r,   out_count_nxt;

  logic [TIME_W-1:0] age;
  logic              stale;
  logic              over_cap;
  logic [IDX_W-1:0]  victim;
  logic              bump;

  // --------------------------------------------------------------------------
  // Configuration: plain write, unknown index ignored
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
      max_r <= MAX_ENTRIES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TTL_MS:      ttl_r <= cfg_wdata[TIME_W-1:0];
        CFG_MAX_ENTRIES: max_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid)              state_nxt = ST_SCAN;
      ST_SCAN:   if (ch_flags[SLOTS].valid) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free)              state_nxt = ST_IDLE;
      default:                              state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    capture  = 1'b0;
    fire     = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   capture  = ch_flags[SLOTS].valid;
      ST_FINISH: fire     = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_valid && in_ready;
    end
  end

  // hold the request while it is searched
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_op_r     <= in_operation;
      q_tag_r    <= in_key_tag;
      q_stamp_r  <= in_version_stamp;
      q_now_r    <= in_now_ms;
      q_handle_r <= HANDLE_BITS'(in_payload_handle);
      q_count_r  <= in_entry_count;
    end
  end

  // --------------------------------------------------------------------------
  // Cell row: token enters at cell 0 and walks one cell per cycle
  // --------------------------------------------------------------------------
  always_comb begin
    ch_flags[0]       = '0;
    ch_flags[0].valid = start_r;
  end
  assign ch_match_idx[0] = '0;
  assign ch_free_idx[0]  = '0;
  assign ch_lru_idx[0]   = '0;
  assign ch_lru_rec[0]   = '0;
  assign ch_data[0]      = '0;
  assign ch_handle[0]    = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lrc_cell #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS),
      .CELL_IDX    (i)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .q_tag          (q_tag_r),
      .q_stamp        (q_stamp_r),
      .q_time         (q_now_r),
      .q_handle       (q_handle_r),
      .q_count        (q_count_r),
      .wr             (wr),
      .wr_idx         (wr_idx),
      .wr_rec         (rec_inc),
      .sin_flags      (ch_flags[i]),
      .sin_match_idx  (ch_match_idx[i]),
      .sin_free_idx   (ch_free_idx[i]),
      .sin_lru_idx    (ch_lru_idx[i]),
      .sin_lru_rec    (ch_lru_rec[i]),
      .sin_data       (ch_data[i]),
      .sin_handle     (ch_handle[i]),
      .sout_flags     (ch_flags[i+1]),
      .sout_match_idx (ch_match_idx[i+1]),
      .sout_free_idx  (ch_free_idx[i+1]),
      .sout_lru_idx   (ch_lru_idx[i+1]),
      .sout_lru_rec   (ch_lru_rec[i+1]),
      .sout_data      (ch_data[i+1]),
      .sout_handle    (ch_handle[i+1])
    );
  end

  // capture the token as it leaves the last cell
  always_ff @(posedge clk) begin
    if (capture) begin
      res_flags_r     <= ch_flags[SLOTS];
      res_match_idx_r <= ch_match_idx[SLOTS];
      res_free_idx_r  <= ch_free_idx[SLOTS];
      res_lru_idx_r   <= ch_lru_idx[SLOTS];
      res_data_r      <= ch_data[SLOTS];
      res_handle_r    <= ch_handle[SLOTS];
    end
  end

  // --------------------------------------------------------------------------
  // Finish: freshness check, victim choice, slot update, result
  // --------------------------------------------------------------------------
  assign age      = q_now_r - res_data_r.stored_time;
  assign stale    = (res_data_r.stamp != q_stamp_r) || (age >= ttl_r);
  assign over_cap = q_count_r > max_r;
  assign rec_inc  = rec_ctr_r + REC_W'(1);

  // matching slot first, then highest free slot, then least recently used
  assign victim = res_flags_r.match      ? res_match_idx_r :
                  res_flags_r.free_found ? res_free_idx_r  : res_lru_idx_r;

  always_comb begin
    wr              = '0;
    wr_idx          = res_match_idx_r;
    bump            = 1'b0;
    out_hit_nxt     = 1'b0;
    out_expired_nxt = 1'b0;
    out_stored_nxt  = 1'b0;
    out_slot_nxt    = '0;
    out_handle_nxt  = '0;
    out_count_nxt   = '0;
    if (q_op_r == OP_GET) begin
      if (res_flags_r.match && stale) begin
        // drop the stale slot
        wr.clear        = fire;
        out_expired_nxt = 1'b1;
        out_slot_nxt    = SLOT_W'(res_match_idx_r);
      end else if (res_flags_r.match) begin
        // hit: mark most recent
        wr.touch       = fire;
        bump           = fire;
        out_hit_nxt    = 1'b1;
        out_slot_nxt   = SLOT_W'(res_match_idx_r);
        out_handle_nxt = HOUT_W'(res_handle_r);
        out_count_nxt  = res_data_r.count;
      end
    end else if (!over_cap) begin
      wr.store       = fire;
      wr_idx         = victim;
      bump           = fire;
      out_stored_nxt = 1'b1;
      out_slot_nxt   = SLOT_W'(victim);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_ctr_r <= '0;
    end else if (bump) begin
      rec_ctr_r <= rec_inc;
    end
  end

  // output register: refill on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      out_hit_r     <= out_hit_nxt;
      out_expired_r <= out_expired_nxt;
      out_stored_r  <= out_stored_nxt;
      out_slot_r    <= out_slot_nxt;
      out_handle_r  <= out_handle_nxt;
      out_count_r   <= out_count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_expired       = out_expired_r;
  assign out_stored        = out_stored_r;
  assign out_slot_used     = out_slot_r;
  assign out_result_handle = out_handle_r;
  assign out_result_count  = out_count_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_hit_r, out_expired_r, out_stored_r}))
    else $error("more than one outcome flag set");

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ch_flags[SLOTS].valid |-> (state_r == ST_SCAN))
    else $error("search token left the row outside the scan step");

  a_start_token: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (start_r && (state_r == ST_SCAN)))
    else $error("accepted request did not launch a search");

  a_rec_moves_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_ctr_r != $past(rec_ctr_r)) |-> $past(fire))
    else $error("recency counter moved outside a finish");

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("finished request produced no result");

endmodule
